// ===== rtl/bpl_pkg.sv =====
// Package for the bounded positional list: sizes, operation codes,
// request/response payload types and the per-cell control struct.
// No dependencies.
package bpl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;

  // Operation codes carried in the request
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_LOCATE = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
    logic                     full_res;
    logic                     empty_res;
  } rsp_t;

  // Per-cell update command for one accepted request
  typedef struct packed {
    logic take_left;   // insert: shift up from lower neighbor
    logic take_right;  // delete: shift down from upper neighbor
    logic load;        // insert/set: write the request value
  } cell_ctl_t;

endpackage

// ===== rtl/bpl_cell.sv =====
// One storage cell of the list chain: holds a single entry, shifts from
// either neighbor or loads a new value, and compares against a search key.
// Depends on bpl_pkg.
module bpl_cell (
  input  logic                             clk,
  input  bpl_pkg::cell_ctl_t               ctl,
  input  logic signed [bpl_pkg::DATA_W-1:0] left_val,
  input  logic signed [bpl_pkg::DATA_W-1:0] right_val,
  input  logic signed [bpl_pkg::DATA_W-1:0] wr_val,
  input  logic signed [bpl_pkg::DATA_W-1:0] key,
  output logic signed [bpl_pkg::DATA_W-1:0] val,
  output logic                             hit
);
  import bpl_pkg::*;

  // Entry register; contents undefined until first written
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= wr_val;
    end else if (ctl.take_left) begin
      val <= left_val;
    end else if (ctl.take_right) begin
      val <= right_val;
    end
  end

  // Equality compare for locate; top level masks by occupancy
  assign hit = (val == key);

endmodule

// ===== rtl/bounded_positional_list.sv =====
// Top level of the bounded positional list: a chain of entry cells plus
// the fill count, request decode and the registered response.
// Depends on bpl_pkg and bpl_cell.
//
// Usage:
//   Requests arrive on req_valid/req_ready with a req_t payload (op, pos,
//   value). Each request yields exactly one response on rsp_valid/rsp_ready
//   with an rsp_t payload (ok, data, count, full_res, empty_res).
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one request per cycle unless the receiver stalls. All cells
//   shift, load and compare in the same cycle, so insert and delete move the
//   whole list at once and locate checks every occupied cell in parallel.
//   The response register doubles as the stall buffer: a new request is
//   taken whenever the response register is empty or being drained in the
//   same cycle. While the receiver stalls, req_ready stays low and the
//   pending response holds.
//   Reset (rst, synchronous) empties the list and drops any pending
//   response; entry contents are not cleared, as only occupied positions
//   are ever read.
module bounded_positional_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpl_pkg::rsp_t rsp
);
  import bpl_pkg::*;

  logic [CNT_W-1:0]          fill_count;
  logic [CNT_W-1:0]          fill_count_next;
  logic                      req_fire;
  logic signed [DATA_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_hit;
  cell_ctl_t                 cell_ctl [CAPACITY];
  logic                      pos_in_list;
  logic                      ins_ok;
  logic                      found;
  logic [IDX_W-1:0]          found_idx;
  logic signed [DATA_W-1:0]  get_val;
  rsp_t                      rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;

  // Bounds checks against the current fill count
  assign pos_in_list = (req.pos < fill_count);
  assign ins_ok      = (fill_count < CNT_W'(CAPACITY)) && (req.pos <= fill_count);

  // Cell chain with per-cell update decode
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY-1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    always_comb begin
      cell_ctl[i] = '0;
      if (req_fire) begin
        unique case (req.op)
          OP_INSERT: begin
            if (ins_ok) begin
              cell_ctl[i].load      = (req.pos == POS_W'(i));
              cell_ctl[i].take_left = (POS_W'(i) > req.pos) && (CNT_W'(i) <= fill_count);
            end
          end
          OP_DELETE: begin
            if (pos_in_list) begin
              cell_ctl[i].take_right = (POS_W'(i) >= req.pos) &&
                                       (CNT_W'(i + 1) < fill_count);
            end
          end
          OP_SET: begin
            if (pos_in_list) begin
              cell_ctl[i].load = (req.pos == POS_W'(i));
            end
          end
          default: ;
        endcase
      end
    end

    bpl_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .left_val  (left_val),
      .right_val (right_val),
      .wr_val    (req.value),
      .key       (req.value),
      .val       (cell_val[i]),
      .hit       (cell_hit[i])
    );
  end

  // Read select and lowest-index match over occupied cells
  always_comb begin
    get_val   = '0;
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (req.pos == POS_W'(i)) begin
        get_val = get_val | cell_val[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i] && (CNT_W'(i) < fill_count)) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // Response and next fill count
  always_comb begin
    fill_count_next = fill_count;
    rsp_next        = '0;
    unique case (req.op)
      OP_INSERT: begin
        rsp_next.ok = ins_ok;
        if (ins_ok) begin
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        rsp_next.ok = pos_in_list;
        if (pos_in_list) begin
          fill_count_next = fill_count - CNT_W'(1);
        end
      end
      OP_GET: begin
        rsp_next.ok = pos_in_list;
        if (pos_in_list) begin
          rsp_next.data = get_val;
        end
      end
      OP_SET: begin
        rsp_next.ok = pos_in_list;
      end
      OP_LOCATE: begin
        rsp_next.ok = found;
        if (found) begin
          rsp_next.data = {{(DATA_W-IDX_W){1'b0}}, found_idx};
        end
      end
      default: ;
    endcase
    rsp_next.count     = fill_count_next;
    rsp_next.full_res  = (fill_count_next == CNT_W'(CAPACITY));
    rsp_next.empty_res = (fill_count_next == '0);
  end

  // Fill count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_fire) begin
        fill_count <= fill_count_next;
        rsp        <= rsp_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !req_fire |=> $stable(fill_count))
    else $error("fill count changed without a request");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.op == OP_INSERT) && ins_ok |=>
      fill_count == $past(fill_count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (rsp.count == fill_count) && rsp_valid)
    else $error("response count differs from fill count");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.full_res && rsp.empty_res))
    else $error("full and empty both set");

endmodule
